[rtl/core/enrichment_running_sum_score_unit_defines.svh]
// Assertion macros for the enrichment score unit
`ifndef ENRICHMENT_RUNNING_SUM_SCORE_UNIT_DEFINES_SVH
`define ENRICHMENT_RUNNING_SUM_SCORE_UNIT_DEFINES_SVH

// Check that a condition implies a consequence on the same edge
`define ERS_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence on the next edge
`define ERS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/ers_pkg.sv]
`timescale 1ns / 1ps
package ers_pkg;
	localparam int MaxEntries = 1024;
	localparam int ScoreBits  = 32;
	localparam int FracBits   = 30;

	localparam logic [1:0] StatusOk     = 2'd0;
	localparam logic [1:0] StatusNoHits = 2'd1;
	localparam logic [1:0] StatusNoMiss = 2'd2;

	typedef enum logic [8:0] {
		ST_LOAD  = 9'b000000001,
		ST_SORTI = 9'b000000010,
		ST_SORTR = 9'b000000100,
		ST_SORTC = 9'b000001000,
		ST_SCANR = 9'b000010000,
		ST_SCAN  = 9'b000100000,
		ST_MUL   = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;
endpackage

[rtl/core/enrichment_running_sum_score_unit.sv]
`timescale 1ns / 1ps
// Channel | Dir | Payload
// s_axis  | in  | tdata: score; tuser: in_set; tlast: last_entry
// m_axis  | out | tdata: enrichment; tuser: status
// On the last entry a set with hit weight and misses is ranked by an in-place
// insertion sort over one memory, one read-modify-write shift per cycle and
// O(N^2) shifts worst case; any other set is closed at once. The scan then
// visits each ranked entry in SCANR, SCAN and MUL before a bit-serial divide.
// arst_n clears all control state; stores are undefined until written.
// s_axis stalls from the last entry until the result is taken from m_axis.
module enrichment_running_sum_score_unit #(
	parameter int MAX_ENTRIES = ers_pkg::MaxEntries,
	parameter int SCORE_BITS  = ers_pkg::ScoreBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] score
	input  logic        s_axis_tuser,  // [0] in_set
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] enrichment
	output logic [1:0]  m_axis_tuser   // [1:0] status
);
`include "enrichment_running_sum_score_unit_defines.svh"

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int HW = SCORE_BITS + CW;
	localparam int PW = HW + CW + 1;
	localparam int DW = PW + ers_pkg::FracBits + 2;
	localparam int QW = 32;
	localparam int MW = SCORE_BITS + 1;

	// Entry memory: score with membership flag
	logic [MW-1:0] mem [MAX_ENTRIES];
	logic [MW-1:0] rd_s1;
	logic          we;
	logic [AW-1:0] wa, ra;
	logic [MW-1:0] wd;

	ers_pkg::state_t st_q;
	logic [CW-1:0] cnt_q, i_q, j_q;
	logic [HW-1:0] hit_q, hsum_q;
	logic [CW-1:0] miss_q, msum_q;
	logic [PW-1:0] max_q, min_q, a_q, b_q, den_q;
	logic [MW-1:0] v_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [5:0]    k_q;
	logic          neg_q;
	logic [31:0]   res_q;
	logic [1:0]    status_q;
	logic          ovalid_q;

	function automatic logic [SCORE_BITS-1:0] mag_f(input logic [SCORE_BITS-1:0] s);
		mag_f = s[SCORE_BITS-1] ? (~s + 1'b1) : s;
	endfunction

	logic acc;
	assign s_axis_tready = (st_q == ers_pkg::ST_LOAD) && !ovalid_q;
	assign acc = s_axis_tvalid && s_axis_tready;

	logic [SCORE_BITS-1:0] in_s;
	assign in_s = s_axis_tdata[SCORE_BITS-1:0];

	// Compare keys: move the held entry above a smaller predecessor
	logic lt;
	assign lt = ({~rd_s1[MW-1], rd_s1[MW-2:1]} < {~v_q[MW-1], v_q[MW-2:1]});

	// Memory port selection
	always_comb begin
		we = 1'b0;
		wa = cnt_q[AW-1:0];
		wd = {in_s, s_axis_tuser};
		ra = '0;
		case (st_q)
			ers_pkg::ST_LOAD: begin
				we = acc && (cnt_q < CW'(MAX_ENTRIES));
			end
			ers_pkg::ST_SORTI: begin
				ra = i_q[AW-1:0];
			end
			ers_pkg::ST_SORTR: begin
				ra = AW'(j_q - 1'b1);
			end
			ers_pkg::ST_SORTC: begin
				ra = AW'(j_q - 2'd2);
				wa = j_q[AW-1:0];
				we = 1'b1;
				wd = (j_q != '0 && lt) ? rd_s1 : v_q;
			end
			ers_pkg::ST_SCANR: begin
				ra = i_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// Memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_s1 <= mem[ra];
	end

	logic [DW-1:0] rem2;
	assign rem2 = {rem_q[DW-2:0], 1'b0};

	// Sequencer: load, rank, scan, divide, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ers_pkg::ST_LOAD;
			cnt_q <= '0; hit_q <= '0; miss_q <= '0;
			max_q <= '0; min_q <= '0; ovalid_q <= 1'b0;
			i_q <= '0; j_q <= '0; k_q <= '0;
		end else begin
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			case (st_q)
				ers_pkg::ST_LOAD: if (acc) begin
					logic [CW-1:0] m_n;
					logic [HW-1:0] h_n;
					logic [CW-1:0] c_n;
					m_n = miss_q; h_n = hit_q; c_n = cnt_q;
					if (cnt_q < CW'(MAX_ENTRIES)) begin
						c_n = cnt_q + 1'b1;
						if (s_axis_tuser) h_n = hit_q + HW'(mag_f(in_s));
						else m_n = miss_q + 1'b1;
					end
					// Close a set without hit weight or without misses at once
					if (s_axis_tlast && (h_n == '0 || m_n == '0)) begin
						res_q <= '0;
						status_q <= (h_n == '0) ? ers_pkg::StatusNoHits :
							ers_pkg::StatusNoMiss;
						ovalid_q <= 1'b1; cnt_q <= '0; hit_q <= '0; miss_q <= '0;
					end else begin
						cnt_q <= c_n; hit_q <= h_n; miss_q <= m_n;
						if (s_axis_tlast) begin
							i_q <= CW'(1);
							st_q <= ers_pkg::ST_SORTI;
						end
					end
				end
				ers_pkg::ST_SORTI: begin
					if (i_q >= cnt_q) begin
						i_q <= '0; hsum_q <= '0; msum_q <= '0;
						st_q <= ers_pkg::ST_SCANR;
					end else begin
						j_q <= i_q;
						st_q <= ers_pkg::ST_SORTR;
					end
				end
				ers_pkg::ST_SORTR: begin
					v_q <= rd_s1;
					st_q <= ers_pkg::ST_SORTC;
				end
				ers_pkg::ST_SORTC: begin
					if (j_q != '0 && lt) j_q <= j_q - 1'b1;
					else begin
						i_q <= i_q + 1'b1;
						st_q <= ers_pkg::ST_SORTI;
					end
				end
				ers_pkg::ST_SCANR: begin
					st_q <= ers_pkg::ST_SCAN;
				end
				ers_pkg::ST_SCAN: begin
					logic [HW-1:0] hs;
					logic [CW-1:0] ms;
					hs = hsum_q; ms = msum_q;
					if (rd_s1[0]) hs = hsum_q + HW'(mag_f(rd_s1[MW-1:1]));
					else ms = msum_q + 1'b1;
					hsum_q <= hs; msum_q <= ms;
					st_q <= ers_pkg::ST_MUL;
				end
				ers_pkg::ST_MUL: begin
					logic [PW-1:0] a, b;
					a = PW'(hsum_q) * PW'(miss_q);
					b = PW'(msum_q) * PW'(hit_q);
					if (a >= b) begin
						if (a - b > max_q) max_q <= a - b;
					end else if (b - a > min_q) min_q <= b - a;
					if (i_q + 1'b1 >= cnt_q) begin
						st_q <= ers_pkg::ST_DIV;
						k_q <= '0;
						den_q <= PW'(hit_q) * PW'(miss_q);
						a_q <= max_q; b_q <= min_q;
					end else begin
						i_q <= i_q + 1'b1;
						st_q <= ers_pkg::ST_SCANR;
					end
				end
				ers_pkg::ST_DIV: begin
					if (k_q == '0) begin
						neg_q <= b_q > a_q;
						rem_q <= DW'((b_q > a_q) ? b_q - a_q : a_q - b_q);
						quo_q <= '0;
						k_q <= 6'd1;
					end else if (k_q <= 6'd32) begin
						// Restoring division: two integer bits then thirty fraction bits
						if (k_q <= 6'd2) begin
							if (rem_q >= (DW'(den_q) << (2'd2 - k_q[1:0]))) begin
								rem_q <= rem_q - (DW'(den_q) << (2'd2 - k_q[1:0]));
								quo_q <= {quo_q[QW-2:0], 1'b1};
							end else quo_q <= {quo_q[QW-2:0], 1'b0};
						end else begin
							if (rem2 >= DW'(den_q)) begin
								rem_q <= rem2 - DW'(den_q);
								quo_q <= {quo_q[QW-2:0], 1'b1};
							end else begin
								rem_q <= rem2;
								quo_q <= {quo_q[QW-2:0], 1'b0};
							end
						end
						k_q <= k_q + 1'b1;
					end else begin
						res_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
						status_q <= ers_pkg::StatusOk;
						st_q <= ers_pkg::ST_OUT;
					end
				end
				ers_pkg::ST_OUT: begin
					ovalid_q <= 1'b1;
					cnt_q <= '0; hit_q <= '0; miss_q <= '0;
					max_q <= '0; min_q <= '0;
					st_q <= ers_pkg::ST_LOAD;
				end
				default: st_q <= ers_pkg::ST_LOAD;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = res_q;
	assign m_axis_tuser = status_q;

	`ERS_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, st_q != ers_pkg::ST_LOAD, !s_axis_tready, "input accepted while busy")
	`ERS_ASSERT_NEXT(a_hold_out, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
	`ERS_ASSERT_IMPL(a_status_ok_range, clk, arst_n, m_axis_tvalid && m_axis_tuser != ers_pkg::StatusOk, m_axis_tdata == '0, "nonzero result on bad status")
endmodule

[sim/enrichment_running_sum_score_unit_tb.sv]
`timescale 1ns / 1ps
module enrichment_running_sum_score_unit_tb;

	localparam int CycleLimit = 4000000;

	typedef struct packed {
		logic [31:0] score;
		logic        in_set;
		logic        last_entry;
	} entry_t;

	typedef struct packed {
		logic [31:0] enrichment;
		logic [1:0]  status;
	} score_result_t;

	// one directed row: the item, and a typed-in result where one is obvious
	typedef struct packed {
		entry_t        entry;
		logic          typed;
		score_result_t result;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // [31:0] score
	logic        s_axis_tuser;  // [0] in_set
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;  // [31:0] enrichment
	logic [1:0]  m_axis_tuser;  // [1:0] status

	// ranked-set model state
	logic [31:0]   set_scores[$];
	bit            set_members[$];
	logic [63:0]   weight_total;
	int unsigned   miss_count;
	score_result_t pending_scores[$];
	int            error_count = 0;
	int unsigned   cycle_count = 0;

	enrichment_running_sum_score_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] magnitude(logic [31:0] s);
		return s[31] ? {32'd0, -s} : {32'd0, s};
	endfunction

	// random idling, with a quiet stretch where both sides run flat out
	function automatic bit idle_now();
		if (cycle_count >= 20000 && cycle_count < 45000)
			return 1'b0;
		return $urandom_range(99) < 11;
	endfunction

	// add one entry to the set; return 1 with the score when it closes the set
	function automatic bit score_entry(entry_t e, output score_result_t r);
		int unsigned order[$];
		int unsigned n, i, j, v;
		logic [63:0] hit_run, miss_run, a, b, best_up, best_down, den, mag, q, rem;
		bit neg;
		if (set_scores.size() < ers_pkg::MaxEntries) begin
			set_scores.push_back(e.score);
			set_members.push_back(e.in_set);
			if (e.in_set)
				weight_total += magnitude(e.score);
			else
				miss_count++;
		end
		if (!e.last_entry)
			return 1'b0;
		r = '0;
		if (weight_total == 0) begin
			r.status = ers_pkg::StatusNoHits;
		end else if (miss_count == 0) begin
			r.status = ers_pkg::StatusNoMiss;
		end else begin
			// stable descending insertion sort by signed score
			n = set_scores.size();
			for (i = 0; i < n; i++)
				order.push_back(i);
			for (i = 1; i < n; i++) begin
				v = order[i];
				j = i;
				while (j > 0 && $signed(set_scores[order[j-1]]) < $signed(set_scores[v])) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = v;
			end
			// walk the ranked list over the common denominator
			hit_run = 0;
			miss_run = 0;
			best_up = 0;
			best_down = 0;
			for (i = 0; i < n; i++) begin
				if (set_members[order[i]])
					hit_run += magnitude(set_scores[order[i]]);
				else
					miss_run++;
				a = hit_run * miss_count;
				b = miss_run * weight_total;
				if (a >= b) begin
					if (a - b > best_up)
						best_up = a - b;
				end else if (b - a > best_down) begin
					best_down = b - a;
				end
			end
			den = weight_total * miss_count;
			neg = best_down > best_up;
			mag = neg ? best_down - best_up : best_up - best_down;
			q = mag / den;
			rem = mag % den;
			for (i = 0; i < ers_pkg::FracBits; i++) begin
				rem = rem << 1;
				q = q << 1;
				if (rem >= den) begin
					rem -= den;
					q[0] = 1'b1;
				end
			end
			r.enrichment = neg ? -q[31:0] : q[31:0];
			r.status = ers_pkg::StatusOk;
		end
		set_scores.delete();
		set_members.delete();
		weight_total = 0;
		miss_count = 0;
		return 1'b1;
	endfunction

	// present one item, hold until taken, then predict
	task automatic send_entry(entry_t e, bit typed = 1'b0,
			score_result_t fixed = '0);
		score_result_t r;
		@(negedge clk);
		while (idle_now()) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = e.score;
		s_axis_tuser = e.in_set;
		s_axis_tlast = e.last_entry;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (score_entry(e, r))
			pending_scores.push_back(typed ? fixed : r);
	endtask

	function automatic logic [31:0] random_score();
		int unsigned pick;
		pick = $urandom_range(15);
		if (pick < 4)
			return $signed($urandom_range(4)) - 2 <<< 16;
		if (pick == 4)
			return 32'h8000_0000;
		if (pick == 5)
			return 32'h7fff_ffff;
		return $urandom;
	endfunction

	// hold the result side stalls at random
	always @(negedge clk) begin
		cycle_count <= cycle_count + 1;
		m_axis_tready <= !idle_now();
	end

	// compare each taken result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_scores.size() == 0) begin
				$display("%0t: unexpected result enrichment %h status %0d", $time,
					m_axis_tdata, m_axis_tuser);
				error_count++;
			end else begin
				if (m_axis_tdata !== pending_scores[0].enrichment) begin
					$display("%0t: enrichment expected %h actual %h", $time,
						pending_scores[0].enrichment, m_axis_tdata);
					error_count++;
				end
				if (m_axis_tuser !== pending_scores[0].status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						pending_scores[0].status, m_axis_tuser);
					error_count++;
				end
				void'(pending_scores.pop_front());
			end
		end
	end

	// end the run if the block hangs
	always @(posedge clk) begin
		if (cycle_count > CycleLimit) begin
			$display("enrichment_running_sum_score_unit regression: fail");
			$finish;
		end
	end

	directed_row_t directed[] = '{
		// lone hit: no misses
		'{'{32'h0001_0000, 1'b1, 1'b1}, 1'b1, '{32'd0, ers_pkg::StatusNoMiss}},
		// lone miss: empty set
		'{'{32'h0001_0000, 1'b0, 1'b1}, 1'b1, '{32'd0, ers_pkg::StatusNoHits}},
		// zero hit weight
		'{'{32'h0000_0000, 1'b1, 1'b0}, 1'b0, '0},
		'{'{32'h0002_0000, 1'b0, 1'b1}, 1'b1, '{32'd0, ers_pkg::StatusNoHits}},
		// top hit over a miss: full positive score
		'{'{32'h7fff_ffff, 1'b1, 1'b0}, 1'b0, '0},
		'{'{32'h8000_0000, 1'b0, 1'b1}, 1'b1, '{32'h4000_0000, ers_pkg::StatusOk}},
		// top miss over the most negative hit: full negative score
		'{'{32'h7fff_ffff, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'h8000_0000, 1'b1, 1'b1}, 1'b1, '{32'hc000_0000, ers_pkg::StatusOk}},
		// ties keep arrival order
		'{'{32'h0001_0000, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'h0001_0000, 1'b1, 1'b0}, 1'b0, '0},
		'{'{32'h0001_0000, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'h0001_0000, 1'b1, 1'b1}, 1'b0, '0},
		// mixed signs
		'{'{32'hfffe_8000, 1'b1, 1'b0}, 1'b0, '0},
		'{'{32'h0003_0000, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'h0000_0001, 1'b1, 1'b0}, 1'b0, '0},
		'{'{32'hffff_ffff, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'h1234_5678, 1'b1, 1'b1}, 1'b0, '0},
		// all hits, two entries
		'{'{32'h0005_0000, 1'b1, 1'b0}, 1'b0, '0},
		'{'{32'hfffb_0000, 1'b1, 1'b1}, 1'b1, '{32'd0, ers_pkg::StatusNoMiss}}
	};

	initial begin
		entry_t e;
		int unsigned set_size, hit_odds, sent, k;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		weight_total = 0;
		miss_count = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_entry(directed[i].entry, directed[i].typed, directed[i].result);

		// random sets, mostly small
		sent = 0;
		while (sent < 750) begin
			set_size = $urandom_range(24, 1);
			hit_odds = $urandom_range(90, 10);
			for (k = 0; k < set_size; k++) begin
				e.score = random_score();
				e.in_set = $urandom_range(99) < hit_odds;
				e.last_entry = (k == set_size - 1);
				send_entry(e);
			end
			sent += set_size;
		end

		// one set past the store size: the overflow entries are dropped
		for (k = 0; k < ers_pkg::MaxEntries + 6; k++) begin
			e.score = random_score();
			e.in_set = $urandom_range(3) == 0;
			e.last_entry = (k == ers_pkg::MaxEntries + 5);
			send_entry(e);
		end

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("enrichment_running_sum_score_unit regression: pass");
		else
			$display("enrichment_running_sum_score_unit regression: fail");
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ers_pkg.sv
rtl/core/enrichment_running_sum_score_unit.sv
sim/enrichment_running_sum_score_unit_tb.sv
